[rtl/rlcl_pkg.sv]
// ----------------------------------------------------------------------------
// rlcl_pkg
// Shared types and constants for the ROM line cache lookup and replacement
// control: request and result beats, controller state, command and status.
// ----------------------------------------------------------------------------
`default_nettype none

package rlcl_pkg;

  // Field widths of the request and result beats
  localparam int ADDR_W     = 26;
  localparam int LEN_W      = 27;
  localparam int SLOT_W     = 3;
  localparam int LINE_OFF_W = 12;
  localparam int SKIP_W     = 5;

  // Line geometry and bypass alignment
  localparam int LINE_SHIFT     = 12;
  localparam int LINE_BYTES     = 1 << LINE_SHIFT;
  localparam int TAG_W          = ADDR_W - LINE_SHIFT;
  localparam int TRANSFER_ALIGN = 32;

  // End-offset arithmetic is carried without wrap
  localparam int SUM_W = ADDR_W + 2;

  // Use stamps
  localparam int STAMP_W = 32;

  typedef struct packed {
    logic [ADDR_W-1:0] read_offset;
    logic [LEN_W-1:0]  read_length;
  } rlcl_in_t;

  typedef struct packed {
    logic                  hit;
    logic                  bypass;
    logic [SLOT_W-1:0]     slot;
    logic [LINE_OFF_W-1:0] line_byte_offset;
    logic [ADDR_W-1:0]     transfer_start;
    logic [LEN_W-1:0]      transfer_bytes;
    logic [SKIP_W-1:0]     skip_bytes;
  } rlcl_out_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_SCAN,
    ST_FILL
  } rlcl_state_t;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic emit_direct;
    logic scan_init;
    logic scan_step;
    logic emit_fill;
  } rlcl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic direct;
    logic scan_last;
  } rlcl_status_t;

endpackage

`default_nettype wire

[rtl/rom_line_cache_lookup_policy_top.sv]
// ----------------------------------------------------------------------------
// rom_line_cache_lookup_policy_top
// Tag and LRU replacement control for a fully associative ROM line cache.
// ----------------------------------------------------------------------------
// A request beat is taken when start is high and busy is low. A hit or a
// line-crossing bypass is answered from the evaluate state through the
// result register. A miss walks the use stamps one entry a cycle to find
// the least recently used slot and then writes the fill. busy drops in the
// cycle the result is shown, so the next request can be taken then. Results
// appear on out_data for one cycle with out_valid and cannot be held off.
`default_nettype none

module rom_line_cache_lookup_policy_top
  import rlcl_pkg::*;
#(
  parameter int NUM_ENTRIES = 8
) (
  input  wire       clk,
  input  wire       rst_n,
  input  wire       start,
  output logic      busy,
  input  rlcl_in_t  in_data,
  output logic      out_valid,
  output rlcl_out_t out_data
);

  rlcl_cmd_t    cmd;
  rlcl_status_t status;

  // Sequencer
  rlcl_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .status (status),
    .cmd    (cmd)
  );

  // Tags, stamps and result
  rlcl_dpath #(
    .NUM_ENTRIES (NUM_ENTRIES)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

[rtl/rlcl_ctrl.sv]
// ----------------------------------------------------------------------------
// rlcl_ctrl
// Sequencer: takes a request beat, decides between a direct answer and a
// victim scan, steps the scan and finishes with the line fill.
// ----------------------------------------------------------------------------
`default_nettype none

module rlcl_ctrl
  import rlcl_pkg::*;
(
  input  wire          clk,
  input  wire          rst_n,
  input  wire          start,
  output logic         busy,
  input  rlcl_status_t status,
  output rlcl_cmd_t    cmd
);

  rlcl_state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) state_nxt = ST_EVAL;
      end
      ST_EVAL: begin
        state_nxt = status.direct ? ST_IDLE : ST_SCAN;
      end
      ST_SCAN: begin
        if (status.scan_last) state_nxt = ST_FILL;
      end
      ST_FILL: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Outputs
  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      ST_EVAL: begin
        cmd.emit_direct = status.direct;
        cmd.scan_init   = !status.direct;
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
      end
      ST_FILL: begin
        cmd.emit_fill = 1'b1;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

endmodule

`default_nettype wire

[rtl/rlcl_dpath.sv]
// ----------------------------------------------------------------------------
// rlcl_dpath
// Request register, parallel tag match, one-entry-a-cycle victim scan over
// the use stamps, entry state, stamp counter and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module rlcl_dpath
  import rlcl_pkg::*;
#(
  parameter int NUM_ENTRIES = 8
) (
  input  wire          clk,
  input  wire          rst_n,
  input  rlcl_in_t     in_data,
  input  rlcl_cmd_t    cmd,
  output rlcl_status_t status,
  output logic         out_valid,
  output rlcl_out_t    out_data
);

  localparam int IDX_W = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
  localparam logic [SUM_W-1:0]  ALIGN_M_SUM  = SUM_W'(TRANSFER_ALIGN - 1);
  localparam logic [ADDR_W-1:0] ALIGN_M_ADDR = ADDR_W'(TRANSFER_ALIGN - 1);
  localparam logic [ADDR_W-1:0] LINE_M_ADDR  = ADDR_W'(LINE_BYTES - 1);
  localparam int ALIGN_W = (TRANSFER_ALIGN > 1) ? $clog2(TRANSFER_ALIGN) : 1;

  rlcl_in_t               req_r;
  logic [NUM_ENTRIES-1:0] valid_r;
  logic [TAG_W-1:0]       tag_r   [NUM_ENTRIES];
  logic [STAMP_W-1:0]     stamp_r [NUM_ENTRIES];
  logic [STAMP_W-1:0]     stamp_ctr_r;
  logic [IDX_W-1:0]       cand_r;
  logic [STAMP_W-1:0]     cand_stamp_r;
  logic [IDX_W-1:0]       scan_idx_r;
  rlcl_out_t              out_r, out_nxt;
  logic                   out_valid_r;

  logic [LEN_W-1:0]       len_eff;
  logic [SUM_W-1:0]       last_byte;
  logic [TAG_W-1:0]       first_line;
  logic                   bypass;
  logic [NUM_ENTRIES-1:0] match;
  logic                   any_hit;
  logic [IDX_W-1:0]       hit_idx;
  logic [SKIP_W-1:0]      skip;
  logic [SUM_W-1:0]       total;
  logic [SUM_W-1:0]       rounded;
  logic                   cur_valid;
  logic [STAMP_W-1:0]     cur_stamp;
  logic                   take;
  logic                   hit_upd;

  // Request register
  always_ff @(posedge clk) begin
    if (cmd.load) req_r <= in_data;
  end

  // Line crossing check; a zero length counts as one byte
  assign len_eff    = (req_r.read_length == '0) ? LEN_W'(1) : req_r.read_length;
  assign last_byte  = SUM_W'(req_r.read_offset) + SUM_W'(len_eff) - SUM_W'(1);
  assign first_line = req_r.read_offset[ADDR_W-1:LINE_SHIFT];
  assign bypass     = last_byte[SUM_W-1:LINE_SHIFT] != (SUM_W-LINE_SHIFT)'(first_line);

  // Parallel tag match, lowest slot wins
  always_comb begin
    hit_idx = '0;
    for (int i = 0; i < NUM_ENTRIES; i++) begin
      match[i] = valid_r[i] && (tag_r[i] == first_line);
    end
    for (int i = NUM_ENTRIES - 1; i >= 0; i--) begin
      if (match[i]) hit_idx = IDX_W'(i);
    end
  end
  assign any_hit = |match;

  // Bypass window
  assign skip    = SKIP_W'(req_r.read_offset[ALIGN_W-1:0] & ALIGN_M_ADDR[ALIGN_W-1:0]);
  assign total   = SUM_W'(len_eff) + SUM_W'(skip);
  assign rounded = (total + ALIGN_M_SUM) & ~ALIGN_M_SUM;

  // Victim scan step
  assign cur_valid = valid_r[scan_idx_r];
  assign cur_stamp = stamp_r[scan_idx_r];
  assign take      = !cur_valid || (cur_stamp < cand_stamp_r);

  always_ff @(posedge clk) begin
    if (cmd.scan_init) begin
      cand_r       <= '0;
      cand_stamp_r <= stamp_r[0];
      scan_idx_r   <= IDX_W'(1);
    end else if (cmd.scan_step) begin
      if (take) begin
        cand_r       <= scan_idx_r;
        cand_stamp_r <= cur_stamp;
      end
      scan_idx_r <= scan_idx_r + IDX_W'(1);
    end
  end

  assign status.direct    = bypass || any_hit;
  assign status.scan_last = scan_idx_r == IDX_W'(NUM_ENTRIES - 1);

  // Entry state and stamp counter
  assign hit_upd = cmd.emit_direct && !bypass && any_hit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= '0;
      stamp_ctr_r <= '0;
      for (int i = 0; i < NUM_ENTRIES; i++) begin
        stamp_r[i] <= '0;
      end
    end else begin
      if (hit_upd) stamp_r[hit_idx] <= stamp_ctr_r;
      if (cmd.emit_fill) begin
        valid_r[cand_r] <= 1'b1;
        stamp_r[cand_r] <= stamp_ctr_r;
      end
      if (hit_upd || cmd.emit_fill) stamp_ctr_r <= stamp_ctr_r + STAMP_W'(1);
    end
  end

  // Tags are only read behind a valid bit
  always_ff @(posedge clk) begin
    if (cmd.emit_fill) tag_r[cand_r] <= first_line;
  end

  // Result beat
  always_comb begin
    out_nxt                  = '0;
    out_nxt.line_byte_offset = req_r.read_offset[LINE_OFF_W-1:0];
    if (cmd.emit_fill) begin
      out_nxt.slot           = SLOT_W'(cand_r);
      out_nxt.transfer_start = req_r.read_offset & ~LINE_M_ADDR;
      out_nxt.transfer_bytes = LEN_W'(LINE_BYTES);
    end else if (bypass) begin
      out_nxt.bypass         = 1'b1;
      out_nxt.skip_bytes     = skip;
      out_nxt.transfer_start = req_r.read_offset & ~ALIGN_M_ADDR;
      out_nxt.transfer_bytes = rounded[LEN_W-1:0];
    end else begin
      out_nxt.hit  = 1'b1;
      out_nxt.slot = SLOT_W'(hit_idx);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_direct || cmd.emit_fill) out_r <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.emit_direct || cmd.emit_fill;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire

[rtl/rlcl_checker.sv]
// ----------------------------------------------------------------------------
// rlcl_checker
// Port-level checks on request and result beats, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module rlcl_checker
  import rlcl_pkg::*;
(
  input wire       clk,
  input wire       rst_n,
  input wire       start,
  input wire       busy,
  input rlcl_in_t  in_data,
  input wire       out_valid,
  input rlcl_out_t out_data
);

  // An accepted request makes the block busy in the cycle after it is taken
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("request beat taken without going busy");

  // Results of successive requests never land in adjacent cycles
  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for two cycles");

  // Hit and bypass exclude each other
  a_hit_bypass: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data.hit && out_data.bypass))
    else $error("result flagged as both hit and bypass");

  // A hit moves nothing from backing store
  a_hit_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.hit |->
      out_data.transfer_bytes == '0 && out_data.skip_bytes == '0 &&
      out_data.transfer_start == '0)
    else $error("hit result carries a transfer");

  // A fill moves one whole, line-aligned line
  a_fill_line: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.hit && !out_data.bypass |->
      out_data.transfer_bytes == LEN_W'(LINE_BYTES) &&
      out_data.transfer_start[LINE_SHIFT-1:0] == '0)
    else $error("fill result is not one aligned line");

endmodule

bind rom_line_cache_lookup_policy_top rlcl_checker u_rlcl_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_data  (out_data)
);

`default_nettype wire

[tb/rom_line_cache_lookup_policy_top_test.sv]
// ----------------------------------------------------------------------------
// rom_line_cache_lookup_policy_top_test
// Self-checking bench for the ROM line cache tag and LRU replacement control.
// Read requests are queued up front, then driven one beat at a time with
// random start gaps. Each accepted beat is run through a local line-tag and
// use-stamp model. Every result strobe is checked field by field against the
// oldest predicted lookup.
// ----------------------------------------------------------------------------
`default_nettype none

module rom_line_cache_lookup_policy_top_test
  import rlcl_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_SLOTS   = 8;
  localparam int LINE_TAGS_W = SUM_W - LINE_SHIFT;
  localparam int SPAN_W      = SUM_W + 1;
  localparam int RAND_READS  = 1800;
  localparam int POOL_MAX    = 12;
  localparam int DRAIN_CYC   = 3 * (NUM_SLOTS + 2);

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      start = 1'b0;
  logic      busy;
  rlcl_in_t  in_data = '0;
  logic      out_valid;
  rlcl_out_t out_data;

  // Local copy of the tag store
  logic             slot_valid [NUM_SLOTS];
  logic [TAG_W-1:0] slot_tag   [NUM_SLOTS];
  logic [31:0]      slot_stamp [NUM_SLOTS];
  logic [31:0]      stamp_ctr;

  rlcl_in_t  pending_reads[$];
  rlcl_out_t expected_lookups[$];
  int        planned_reads = 0;
  int        accepted_reads = 0;
  int        mismatch_count = 0;

  // Working set of lines for the well-formed part of the stimulus
  logic [TAG_W-1:0] line_pool [POOL_MAX];
  int               pool_span;

  rom_line_cache_lookup_policy_top DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Lookup, replacement and bypass window for one read; updates the tag store on a hit or fill
  function automatic rlcl_out_t predict_lookup(input rlcl_in_t rd);
    logic [LEN_W-1:0]       len;
    logic [SUM_W-1:0]       last_byte;
    logic [TAG_W-1:0]       first_line;
    logic [LINE_TAGS_W-1:0] last_line;
    logic [SPAN_W-1:0]      span;
    rlcl_out_t              res;
    int                     found;
    int                     victim;
    res = '0;
    found = NUM_SLOTS;
    victim = 0;
    // zero length counts as a single byte
    len = (rd.read_length == '0) ? LEN_W'(1) : rd.read_length;
    last_byte = SUM_W'(rd.read_offset) + SUM_W'(len) - SUM_W'(1);
    first_line = rd.read_offset[ADDR_W-1:LINE_SHIFT];
    last_line = last_byte[SUM_W-1:LINE_SHIFT];
    res.line_byte_offset = rd.read_offset[LINE_SHIFT-1:0];
    if (last_line != LINE_TAGS_W'(first_line)) begin
      // line crossing: aligned window, no state change
      res.bypass = 1'b1;
      res.skip_bytes = rd.read_offset[SKIP_W-1:0];
      res.transfer_start = {rd.read_offset[ADDR_W-1:SKIP_W], SKIP_W'(0)};
      span = SPAN_W'(len) + SPAN_W'(res.skip_bytes) + SPAN_W'(TRANSFER_ALIGN - 1);
      span[SKIP_W-1:0] = '0;
      res.transfer_bytes = span[LEN_W-1:0];
    end else begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        if (found == NUM_SLOTS && slot_valid[i] && slot_tag[i] == first_line) found = i;
      end
      if (found < NUM_SLOTS) begin
        res.hit = 1'b1;
        res.slot = SLOT_W'(found);
        slot_stamp[found] = stamp_ctr;
      end else begin
        // LRU scan: invalid entry or strictly older stamp takes over
        for (int i = 0; i < NUM_SLOTS; i++) begin
          if (!slot_valid[i] || slot_stamp[i] < slot_stamp[victim]) victim = i;
        end
        slot_valid[victim] = 1'b1;
        slot_tag[victim] = first_line;
        slot_stamp[victim] = stamp_ctr;
        res.slot = SLOT_W'(victim);
        res.transfer_start = {first_line, LINE_SHIFT'(0)};
        res.transfer_bytes = LEN_W'(LINE_BYTES);
      end
      stamp_ctr = stamp_ctr + 32'd1;
    end
    return res;
  endfunction

  task automatic queue_read(input logic [ADDR_W-1:0] offset, input logic [LEN_W-1:0] len);
    rlcl_in_t rd;
    rd.read_offset = offset;
    rd.read_length = len;
    pending_reads.push_back(rd);
  endtask

  // One random read: mostly in-line reads over a small working set
  function automatic rlcl_in_t random_read();
    rlcl_in_t rd;
    int       kind;
    int       line_off;
    int       room;
    int       pick;
    kind = $urandom_range(99);
    rd.read_offset = ADDR_W'($urandom());
    rd.read_length = LEN_W'($urandom());
    line_off = int'(rd.read_offset[LINE_SHIFT-1:0]);
    room = LINE_BYTES - line_off;
    if (kind < 70) begin
      rd.read_offset[ADDR_W-1:LINE_SHIFT] = line_pool[$urandom_range(pool_span - 1)];
      pick = $urandom_range(99);
      if (pick < 5)       rd.read_length = '0;
      else if (pick < 15) rd.read_length = LEN_W'(room);
      else if (pick < 60) rd.read_length = LEN_W'($urandom_range((room < 64) ? room : 64, 1));
      else                rd.read_length = LEN_W'($urandom_range(room, 1));
    end else if (kind < 85) begin
      // past the line end, mostly by a little
      if ($urandom_range(9) == 0)
        rd.read_length = LEN_W'($urandom_range(1 << 20, LINE_BYTES + 1));
      else
        rd.read_length = LEN_W'(room + $urandom_range(600, 1));
    end else if (kind < 88) begin
      rd.read_length = '0;
    end
    return rd;
  endfunction

  // Driver: start held while a read is pending, dropped at random
  always @(posedge clk) begin
    int idle_pct;
    if (rst_n) begin
      if (start && !busy) begin
        expected_lookups.push_back(predict_lookup(pending_reads.pop_front()));
        accepted_reads++;
      end
      if (accepted_reads < planned_reads / 3)          idle_pct = 22;
      else if (accepted_reads < 2 * planned_reads / 3) idle_pct = 66;
      else                                             idle_pct = 0;
      if (pending_reads.size() > 0 && $urandom_range(99) >= idle_pct) begin
        start <= 1'b1;
        in_data <= pending_reads[0];
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: every result beat against the oldest prediction
  always @(posedge clk) begin
    rlcl_out_t exp_res;
    if (rst_n && out_valid) begin
      if (expected_lookups.size() == 0) begin
        $error("result beat with no lookup outstanding");
        mismatch_count++;
      end else begin
        exp_res = expected_lookups.pop_front();
        if (out_data.hit !== exp_res.hit) begin
          $error("hit: expected %0h, got %0h", exp_res.hit, out_data.hit);
          mismatch_count++;
        end
        if (out_data.bypass !== exp_res.bypass) begin
          $error("bypass: expected %0h, got %0h", exp_res.bypass, out_data.bypass);
          mismatch_count++;
        end
        if (out_data.slot !== exp_res.slot) begin
          $error("slot: expected %0h, got %0h", exp_res.slot, out_data.slot);
          mismatch_count++;
        end
        if (out_data.line_byte_offset !== exp_res.line_byte_offset) begin
          $error("line_byte_offset: expected %0h, got %0h",
                 exp_res.line_byte_offset, out_data.line_byte_offset);
          mismatch_count++;
        end
        if (out_data.transfer_start !== exp_res.transfer_start) begin
          $error("transfer_start: expected %0h, got %0h",
                 exp_res.transfer_start, out_data.transfer_start);
          mismatch_count++;
        end
        if (out_data.transfer_bytes !== exp_res.transfer_bytes) begin
          $error("transfer_bytes: expected %0h, got %0h",
                 exp_res.transfer_bytes, out_data.transfer_bytes);
          mismatch_count++;
        end
        if (out_data.skip_bytes !== exp_res.skip_bytes) begin
          $error("skip_bytes: expected %0h, got %0h", exp_res.skip_bytes, out_data.skip_bytes);
          mismatch_count++;
        end
      end
    end
  end

  // Stimulus, reset and end of run
  initial begin
    for (int i = 0; i < NUM_SLOTS; i++) begin
      slot_valid[i] = 1'b0;
      slot_tag[i] = '0;
      slot_stamp[i] = '0;
    end
    stamp_ctr = '0;

    // Directed: field extremes, zero length, line edges, fill, LRU eviction
    queue_read(26'h0000000, 27'd1);
    queue_read(26'h0000000, 27'd0);
    queue_read(26'h0000000, 27'd4096);
    queue_read(26'h0000FFF, 27'd1);
    queue_read(26'h0000FFF, 27'd2);
    queue_read(26'h3FFFFFF, 27'd1);
    queue_read(26'h3FFFFFF, 27'h7FFFFFF);
    queue_read(26'h3FFF000, 27'd4096);
    queue_read(26'h0000020, 27'd4097);
    queue_read(26'h0000000, 27'h7FFFFFF);
    queue_read(26'h2AAAAB5, 27'h4000000);
    for (int i = 1; i <= 6; i++) queue_read(ADDR_W'(i << LINE_SHIFT) + 26'h10, 27'd8);
    queue_read(26'h0000800, 27'd16);
    queue_read(ADDR_W'(7 << LINE_SHIFT), 27'd1);
    queue_read(ADDR_W'(8 << LINE_SHIFT), 27'd1);
    queue_read(ADDR_W'(7 << LINE_SHIFT) + 26'hFFF, 27'd1);
    queue_read(26'h3FFF000, 27'd1);
    queue_read(ADDR_W'(2 << LINE_SHIFT), 27'd4096);

    // Random reads; the working set shifts every so often
    for (int i = 0; i < POOL_MAX; i++) line_pool[i] = TAG_W'($urandom());
    line_pool[0] = '0;
    line_pool[1] = '1;
    pool_span = 10;
    for (int n = 0; n < RAND_READS; n++) begin
      if (n % 150 == 0) begin
        pool_span = $urandom_range(POOL_MAX, 5);
        line_pool[$urandom_range(POOL_MAX - 1)] = TAG_W'($urandom());
        line_pool[$urandom_range(POOL_MAX - 1)] = TAG_W'($urandom());
      end
      pending_reads.push_back(random_read());
    end
    planned_reads = pending_reads.size();

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    do @(negedge clk); while (pending_reads.size() != 0 || expected_lookups.size() != 0);
    repeat (DRAIN_CYC) @(negedge clk);

    if (expected_lookups.size() != 0) begin
      $error("%0d lookups never answered", expected_lookups.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5ms;
    $display("FAIL");
    $finish;
  end

endmodule

`default_nettype wire
